@@ hdl/dtd_pkg.sv @@
package dtd_pkg;

  localparam int DAY_W = 25;

  // floor(q / 25) == (q * DIV25_RECIP) >> DIV25_SHIFT for every q below 2**14
  localparam int          DIV25_RECIP_W = 15;
  localparam int          DIV25_SHIFT   = 19;
  localparam logic [14:0] DIV25_RECIP   = 15'd20972;

  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [5:0] MINS_PER_HOUR = 6'd60;
  localparam logic [5:0] SECS_PER_MIN  = 6'd60;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_BAD  = 2'd1,
    STATUS_SECOND_BAD = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ORDER_EQUAL   = 2'd0,
    ORDER_LATER   = 2'd1,
    ORDER_EARLIER = 2'd2
  } order_e;

  // Day number and time of day of one checked timestamp
  typedef struct packed {
    logic             ok;
    logic [DAY_W-1:0] days;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
  } stamp_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        len = 5'd31;
      default:                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of the month
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] cum;
    case (month)
      4'd1:    cum = 9'd0;
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

@@ hdl/dtd_stamp.sv @@
module dtd_stamp #(
  parameter int YEAR_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [4:0]            day_i,
  input  logic [3:0]            month_i,
  input  logic [YEAR_WIDTH-1:0] year_i,
  input  logic [4:0]            hour_i,
  input  logic [5:0]            minute_i,
  input  logic [5:0]            second_i,
  output dtd_pkg::stamp_t       stamp_o
);

  localparam int QW = YEAR_WIDTH - 2;
  localparam int PW = QW + dtd_pkg::DIV25_RECIP_W;
  localparam int CW = PW - dtd_pkg::DIV25_SHIFT;
  localparam int MW = YEAR_WIDTH + 9;
  localparam int DW = dtd_pkg::DAY_W;

  // ---------------- stage 1: year products and range checks
  logic [YEAR_WIDTH-1:0] prev_year;
  logic [QW-1:0]         qp_d, qy_d, qp_q, qy_q;
  logic [PW-1:0]         prodp_d, prody_d, prodp_q, prody_q;
  logic [MW-1:0]         p365_d, p365_q;
  logic                  basic_ok_d, basic_ok_q;
  logic [1:0]            ylo_q;
  logic [4:0]            day1_q, hour1_q;
  logic [3:0]            month1_q;
  logic [5:0]            minute1_q, second1_q;

  assign prev_year = year_i - YEAR_WIDTH'(1);
  assign qp_d      = prev_year[YEAR_WIDTH-1:2];
  assign qy_d      = year_i[YEAR_WIDTH-1:2];
  assign prodp_d   = {{dtd_pkg::DIV25_RECIP_W{1'b0}}, qp_d} * {{QW{1'b0}}, dtd_pkg::DIV25_RECIP};
  assign prody_d   = {{dtd_pkg::DIV25_RECIP_W{1'b0}}, qy_d} * {{QW{1'b0}}, dtd_pkg::DIV25_RECIP};
  assign p365_d    = MW'(prev_year) * MW'(9'd365);

  always_comb begin
    basic_ok_d = (year_i != '0) && (month_i inside {[4'd1:4'd12]}) && (day_i != 5'd0) &&
                 (hour_i < dtd_pkg::HOURS_PER_DAY) && (minute_i < dtd_pkg::MINS_PER_HOUR) &&
                 (second_i < dtd_pkg::SECS_PER_MIN);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qp_q       <= qp_d;
      qy_q       <= qy_d;
      prodp_q    <= prodp_d;
      prody_q    <= prody_d;
      p365_q     <= p365_d;
      basic_ok_q <= basic_ok_d;
      ylo_q      <= year_i[1:0];
      day1_q     <= day_i;
      month1_q   <= month_i;
      hour1_q    <= hour_i;
      minute1_q  <= minute_i;
      second1_q  <= second_i;
    end
  end

  // ---------------- stage 2: leap rule, day check, year base
  logic [CW-1:0] cp, cy;
  logic [QW-1:0] cy25;
  logic          leap;
  logic          ok_d, ok2_q;
  logic [DW-1:0] base_d, base_q;
  logic [8:0]    offs_d, offs_q;
  logic [4:0]    hour2_q;
  logic [5:0]    minute2_q, second2_q;

  assign cp   = prodp_q[PW-1:dtd_pkg::DIV25_SHIFT];  // (year-1) / 100
  assign cy   = prody_q[PW-1:dtd_pkg::DIV25_SHIFT];  // year / 100
  assign cy25 = QW'(cy) * QW'(5'd25);
  // divisible by 4, and either not by 100 or also by 400
  assign leap = (ylo_q == 2'b00) && ((qy_q != cy25) || (cy[1:0] == 2'b00));
  assign ok_d = basic_ok_q && (day1_q <= dtd_pkg::month_len(month1_q, leap));

  assign base_d = DW'(p365_q) + DW'(qp_q) - DW'(cp) + DW'(cp[CW-1:2]);
  assign offs_d = dtd_pkg::days_before(month1_q) + 9'(leap && (month1_q > 4'd2)) +
                  9'(day1_q) - 9'd1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok2_q     <= ok_d;
      base_q    <= base_d;
      offs_q    <= offs_d;
      hour2_q   <= hour1_q;
      minute2_q <= minute1_q;
      second2_q <= second1_q;
    end
  end

  // ---------------- stage 3: day number
  dtd_pkg::stamp_t stamp_d, stamp_q;

  always_comb begin
    stamp_d.ok     = ok2_q;
    stamp_d.days   = base_q + DW'(offs_q);
    stamp_d.hour   = hour2_q;
    stamp_d.minute = minute2_q;
    stamp_d.second = second2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stamp_q <= stamp_d;
    end
  end

  assign stamp_o = stamp_q;

endmodule

@@ hdl/datetime_difference_unit.sv @@
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  first_*_i, second_* _i (day..second)
// out      output     out_valid_o/out_ready_i status_o order_o day_count_o hours_o
//                                             minutes_o seconds_o
//
// Four register stages: year products, leap rule and year base, day number,
// compare and borrow chain into the output register. One transaction is taken
// every cycle unless stalled. All stages advance together whenever the output
// register is empty or being drained; out_ready_i low with a full output
// register holds every stage. Reset clears the valid bits only.
module datetime_difference_unit #(
  parameter int YEAR_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  first_day_i,
  input  logic [3:0]  first_month_i,
  input  logic [15:0] first_year_i,
  input  logic [4:0]  first_hour_i,
  input  logic [5:0]  first_minute_i,
  input  logic [5:0]  first_second_i,
  input  logic [4:0]  second_day_i,
  input  logic [3:0]  second_month_i,
  input  logic [15:0] second_year_i,
  input  logic [4:0]  second_hour_i,
  input  logic [5:0]  second_minute_i,
  input  logic [5:0]  second_second_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  order_o,
  output logic [24:0] day_count_o,
  output logic [4:0]  hours_o,
  output logic [5:0]  minutes_o,
  output logic [5:0]  seconds_o
);

  localparam int DW = dtd_pkg::DAY_W;

  logic            en;
  logic            v1_q, v2_q, v3_q, out_valid_q;
  dtd_pkg::stamp_t sa, sb;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  dtd_stamp #(.YEAR_WIDTH(YEAR_WIDTH)) u_first (
    .clk_i    (clk_i),
    .en_i     (en),
    .day_i    (first_day_i),
    .month_i  (first_month_i),
    .year_i   (first_year_i[YEAR_WIDTH-1:0]),
    .hour_i   (first_hour_i),
    .minute_i (first_minute_i),
    .second_i (first_second_i),
    .stamp_o  (sa)
  );

  dtd_stamp #(.YEAR_WIDTH(YEAR_WIDTH)) u_second (
    .clk_i    (clk_i),
    .en_i     (en),
    .day_i    (second_day_i),
    .month_i  (second_month_i),
    .year_i   (second_year_i[YEAR_WIDTH-1:0]),
    .hour_i   (second_hour_i),
    .minute_i (second_minute_i),
    .second_i (second_second_i),
    .stamp_o  (sb)
  );

  // ---------------- stage 4: order and difference with borrows
  dtd_pkg::stamp_t   big, sml;
  dtd_pkg::status_e  status_d;
  dtd_pkg::order_e   order_d;
  logic              a_gt, a_lt;
  logic              bs, bm, bh;
  logic [5:0]        sec_d, min_d;
  logic [4:0]        hr_d;
  logic [DW-1:0]     days_d;

  logic [1:0]        status_q, order_q;
  logic [DW-1:0]     days_q;
  logic [4:0]        hr_q;
  logic [5:0]        min_q, sec_q;

  assign a_gt = {sa.days, sa.hour, sa.minute, sa.second} >
                {sb.days, sb.hour, sb.minute, sb.second};
  assign a_lt = {sa.days, sa.hour, sa.minute, sa.second} <
                {sb.days, sb.hour, sb.minute, sb.second};

  always_comb begin
    big = a_gt ? sa : sb;
    sml = a_gt ? sb : sa;

    bs    = big.second < sml.second;
    sec_d = big.second - sml.second + (bs ? dtd_pkg::SECS_PER_MIN : 6'd0);

    bm    = {1'b0, big.minute} < ({1'b0, sml.minute} + 7'(bs));
    min_d = big.minute - sml.minute - 6'(bs) + (bm ? dtd_pkg::MINS_PER_HOUR : 6'd0);

    bh    = {1'b0, big.hour} < ({1'b0, sml.hour} + 6'(bm));
    hr_d  = big.hour - sml.hour - 5'(bm) + (bh ? dtd_pkg::HOURS_PER_DAY : 5'd0);

    days_d = big.days - sml.days - DW'(bh);

    if (a_gt) begin
      order_d = dtd_pkg::ORDER_LATER;
    end else if (a_lt) begin
      order_d = dtd_pkg::ORDER_EARLIER;
    end else begin
      order_d = dtd_pkg::ORDER_EQUAL;
    end

    if (!sa.ok) begin
      status_d = dtd_pkg::STATUS_FIRST_BAD;
    end else if (!sb.ok) begin
      status_d = dtd_pkg::STATUS_SECOND_BAD;
    end else begin
      status_d = dtd_pkg::STATUS_OK;
    end

    // zero every difference field of a rejected pair
    if (status_d != dtd_pkg::STATUS_OK) begin
      order_d = dtd_pkg::ORDER_EQUAL;
      sec_d   = '0;
      min_d   = '0;
      hr_d    = '0;
      days_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= status_d;
      order_q  <= order_d;
      days_q   <= days_d;
      hr_q     <= hr_d;
      min_q    <= min_d;
      sec_q    <= sec_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign order_o     = order_q;
  assign day_count_o = days_q;
  assign hours_o     = hr_q;
  assign minutes_o   = min_q;
  assign seconds_o   = sec_q;

endmodule

@@ verif/tb_top.sv @@
module tb_top;

  localparam int YEAR_W = 16;
  localparam longint unsigned YEAR_MASK = (64'd1 << YEAR_W) - 1;
  localparam int N_RANDOM = 1600;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
  } ts_t;

  typedef struct packed {
    ts_t  a;
    ts_t  b;
    logic drain;  // wait for every outstanding result before offering this pair
  } pair_t;

  typedef struct packed {
    dtd_pkg::status_e status;
    dtd_pkg::order_e  order;
    logic [24:0]      days;
    logic [4:0]       hours;
    logic [5:0]       minutes;
    logic [5:0]       seconds;
  } diff_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [4:0]  first_day_i = '0;
  logic [3:0]  first_month_i = '0;
  logic [15:0] first_year_i = '0;
  logic [4:0]  first_hour_i = '0;
  logic [5:0]  first_minute_i = '0;
  logic [5:0]  first_second_i = '0;
  logic [4:0]  second_day_i = '0;
  logic [3:0]  second_month_i = '0;
  logic [15:0] second_year_i = '0;
  logic [4:0]  second_hour_i = '0;
  logic [5:0]  second_minute_i = '0;
  logic [5:0]  second_second_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [1:0]  order_o;
  logic [24:0] day_count_o;
  logic [4:0]  hours_o;
  logic [5:0]  minutes_o;
  logic [5:0]  seconds_o;

  datetime_difference_unit #(
    .YEAR_WIDTH(YEAR_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_day_i    (first_day_i),
    .first_month_i  (first_month_i),
    .first_year_i   (first_year_i),
    .first_hour_i   (first_hour_i),
    .first_minute_i (first_minute_i),
    .first_second_i (first_second_i),
    .second_day_i   (second_day_i),
    .second_month_i (second_month_i),
    .second_year_i  (second_year_i),
    .second_hour_i  (second_hour_i),
    .second_minute_i(second_minute_i),
    .second_second_i(second_second_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .order_o        (order_o),
    .day_count_o    (day_count_o),
    .hours_o        (hours_o),
    .minutes_o      (minutes_o),
    .seconds_o      (seconds_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pair_t stim_q[$];
  diff_t diff_q[$];
  int    fail_count = 0;
  int    sent_count = 0;
  int    cyc_count = 0;
  int    n_valid = 0;
  int    n_bad = 0;
  int    n_later = 0;
  int    n_earlier = 0;
  int    n_equal = 0;
  logic  hold_off = 1'b0;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(longint unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic longint unsigned month_days(longint unsigned m, longint unsigned y);
    case (m)
      2:             return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      1, 3, 5, 7, 8,
      10, 12:        return 31;
      default:       return 0;
    endcase
  endfunction

  function automatic bit stamp_ok(ts_t t);
    if (t.year == 0) return 1'b0;
    if (t.month < 1 || t.month > 12) return 1'b0;
    if (t.day == 0 || t.day > month_days(t.month, t.year)) return 1'b0;
    return (t.hour < 24) && (t.minute < 60) && (t.sec < 60);
  endfunction

  // Seconds since 1 Jan of year 1, midnight
  function automatic longint unsigned stamp_secs(ts_t t);
    longint unsigned y, p, d;
    y = t.year;
    p = y - 1;
    d = 365 * p + p / 4 - p / 100 + p / 400;
    for (int m = 1; m < t.month; m++) d += month_days(m, y);
    d += longint'(t.day) - 1;
    return d * 86400 + longint'(t.hour) * 3600 + longint'(t.minute) * 60 + longint'(t.sec);
  endfunction

  function automatic diff_t compute_difference(pair_t p);
    diff_t           r;
    ts_t             a, b;
    longint unsigned sa, sb, d;
    a = p.a;
    b = p.b;
    a.year = 16'(longint'(a.year) & YEAR_MASK);
    b.year = 16'(longint'(b.year) & YEAR_MASK);
    r = '0;
    r.status = dtd_pkg::STATUS_OK;
    r.order = dtd_pkg::ORDER_EQUAL;
    if (!stamp_ok(a)) begin
      r.status = dtd_pkg::STATUS_FIRST_BAD;
      return r;
    end
    if (!stamp_ok(b)) begin
      r.status = dtd_pkg::STATUS_SECOND_BAD;
      return r;
    end
    sa = stamp_secs(a);
    sb = stamp_secs(b);
    if (sa > sb) begin
      r.order = dtd_pkg::ORDER_LATER;
      d = sa - sb;
    end else if (sa < sb) begin
      r.order = dtd_pkg::ORDER_EARLIER;
      d = sb - sa;
    end else begin
      d = 0;
    end
    r.seconds = 6'(d % 60);
    r.minutes = 6'((d / 60) % 60);
    r.hours   = 5'((d / 3600) % 24);
    r.days    = 25'(d / 86400);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic ts_t mk(int d, int mo, int y, int h, int mi, int s);
    ts_t t;
    t.day = 5'(d);
    t.month = 4'(mo);
    t.year = 16'(y);
    t.hour = 5'(h);
    t.minute = 6'(mi);
    t.sec = 6'(s);
    return t;
  endfunction

  function automatic ts_t noise_stamp();
    ts_t t;
    t = ts_t'(42'({$urandom, $urandom}));
    return t;
  endfunction

  function automatic int pick_year();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 65535);
    if (r < 70) return $urandom_range(1890, 2110);
    if (r < 80) return $urandom_range(1, 163) * 400;
    if (r < 90) return $urandom_range(1, 655) * 100;
    return $urandom_range(1, 10);
  endfunction

  function automatic ts_t good_stamp(int y);
    ts_t t;
    t.year = 16'(y);
    t.month = 4'($urandom_range(1, 12));
    t.day = 5'($urandom_range(1, int'(month_days(t.month, y))));
    t.hour = 5'($urandom_range(0, 23));
    t.minute = 6'($urandom_range(0, 59));
    t.sec = 6'($urandom_range(0, 59));
    return t;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int    r, y;
    p.drain = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      p.a = noise_stamp();
      p.b = noise_stamp();
      return p;
    end
    if (r < 22) begin
      p.a = good_stamp(pick_year());
      p.b = noise_stamp();
      if ($urandom_range(0, 1)) begin
        p.b = p.a;
        p.a = noise_stamp();
      end
      return p;
    end
    p.a = good_stamp(pick_year());
    r = $urandom_range(0, 99);
    if (r < 30) begin
      p.b = good_stamp(pick_year());
    end else if (r < 55) begin
      p.b = good_stamp(p.a.year);
    end else if (r < 70) begin
      y = int'(p.a.year) + ($urandom_range(0, 1) ? 1 : -1);
      if (y < 1) y = 1;
      if (y > 65535) y = 65535;
      p.b = good_stamp(y);
    end else if (r < 80) begin
      p.b = p.a;
    end else begin
      // same day, different time of day, often one second apart
      p.b = p.a;
      if ($urandom_range(0, 1)) begin
        p.b.hour = 5'($urandom_range(0, 23));
        p.b.minute = 6'($urandom_range(0, 59));
        p.b.sec = 6'($urandom_range(0, 59));
      end else if (p.b.sec < 59) begin
        p.b.sec = p.b.sec + 6'd1;
      end else begin
        p.b.sec = p.b.sec - 6'd1;
      end
    end
    if ($urandom_range(0, 1)) begin
      p.b = p.a ^ p.b;
      p.a = p.a ^ p.b;
      p.b = p.a ^ p.b;
    end
    return p;
  endfunction

  task automatic add_pair(ts_t a, ts_t b, logic drain = 1'b0);
    pair_t p;
    p.a = a;
    p.b = b;
    p.drain = drain;
    stim_q.push_back(p);
  endtask

  function automatic int next_gap(int n);
    int r;
    if ((n % 400) < 100) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  pair_t drive_pair;
  int    gap_left = 0;
  logic  offer;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        diff_q.push_back(compute_difference(drive_pair));
        sent_count++;
        offer = 1'b0;
        gap_left = next_gap(sent_count);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0 && !(stim_q[0].drain && diff_q.size() > 0)) begin
          drive_pair = stim_q.pop_front();
          offer = 1'b1;
          first_day_i     <= drive_pair.a.day;
          first_month_i   <= drive_pair.a.month;
          first_year_i    <= drive_pair.a.year;
          first_hour_i    <= drive_pair.a.hour;
          first_minute_i  <= drive_pair.a.minute;
          first_second_i  <= drive_pair.a.sec;
          second_day_i    <= drive_pair.b.day;
          second_month_i  <= drive_pair.b.month;
          second_year_i   <= drive_pair.b.year;
          second_hour_i   <= drive_pair.b.hour;
          second_minute_i <= drive_pair.b.minute;
          second_second_i <= drive_pair.b.sec;
        end
      end
      in_valid_i <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure
  // ---------------------------------------------------------------------------
  // Long hold-off: keep ready low so the pipeline fills and
  // in_ready_o drops while the driver keeps offering.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc_count <= cyc_count + 1;
      hold_off <= ((cyc_count % 2000) >= 700) && ((cyc_count % 2000) < 1000);
    end
  end

  int stall_left = 0;

  always @(posedge clk_i) begin
    int r;
    if (rst_ni) begin
      if (stall_left == 0 && (cyc_count % 1000) >= 200) begin
        r = $urandom_range(0, 99);
        if (r < 70) stall_left = 0;
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else if (r < 98) stall_left = $urandom_range(4, 12);
        else stall_left = $urandom_range(20, 50);
      end
      out_ready_i <= (stall_left == 0) && !hold_off;
      if (stall_left > 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------
  task automatic report_bad(string what, diff_t want, diff_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: want status=%0d order=%0d days=%0d %0d:%0d:%0d",
               what, want.status, want.order, want.days,
               want.hours, want.minutes, want.seconds);
      $display("  got status=%0d order=%0d days=%0d %0d:%0d:%0d",
               got.status, got.order, got.days, got.hours, got.minutes, got.seconds);
    end
  endtask

  always @(posedge clk_i) begin
    diff_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status  = dtd_pkg::status_e'(status_o);
      got.order   = dtd_pkg::order_e'(order_o);
      got.days    = day_count_o;
      got.hours   = hours_o;
      got.minutes = minutes_o;
      got.seconds = seconds_o;
      if (diff_q.size() == 0) begin
        report_bad("unexpected transaction", '0, got);
      end else begin
        want = diff_q.pop_front();
        if (want.status == dtd_pkg::STATUS_OK) n_valid++;
        else n_bad++;
        case (want.order)
          dtd_pkg::ORDER_LATER:   n_later++;
          dtd_pkg::ORDER_EARLIER: n_earlier++;
          default:                n_equal++;
        endcase
        if (got.status !== want.status || got.order !== want.order ||
            got.days !== want.days || got.hours !== want.hours ||
            got.minutes !== want.minutes || got.seconds !== want.seconds) begin
          report_bad("mismatch", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int settle;
    // extremes and equal stamps
    add_pair(mk(1, 1, 1, 0, 0, 0), mk(31, 12, 65535, 23, 59, 59));
    add_pair(mk(31, 12, 65535, 23, 59, 59), mk(1, 1, 1, 0, 0, 0));
    add_pair(mk(15, 6, 2024, 12, 30, 30), mk(15, 6, 2024, 12, 30, 30));
    // year zero, and both stamps bad
    add_pair(mk(1, 1, 0, 0, 0, 0), mk(1, 1, 2000, 0, 0, 0));
    add_pair(mk(1, 1, 2000, 0, 0, 0), mk(1, 1, 0, 0, 0, 0));
    add_pair(mk(0, 0, 0, 24, 60, 60), mk(31, 15, 65535, 31, 63, 63));
    // month and day range
    add_pair(mk(1, 13, 2000, 0, 0, 0), mk(1, 1, 2000, 0, 0, 0));
    add_pair(mk(1, 1, 2000, 0, 0, 0), mk(1, 0, 2000, 0, 0, 0));
    add_pair(mk(0, 5, 2000, 0, 0, 0), mk(1, 1, 2000, 0, 0, 0));
    add_pair(mk(1, 1, 2000, 0, 0, 0), mk(31, 4, 2000, 0, 0, 0));
    // leap rule
    add_pair(mk(29, 2, 2024, 1, 2, 3), mk(29, 2, 2000, 4, 5, 6));
    add_pair(mk(29, 2, 2023, 0, 0, 0), mk(1, 1, 2000, 0, 0, 0));
    add_pair(mk(1, 1, 2000, 0, 0, 0), mk(29, 2, 1900, 0, 0, 0));
    add_pair(mk(30, 2, 2000, 0, 0, 0), mk(1, 1, 2000, 0, 0, 0));
    // time of day range
    add_pair(mk(1, 1, 2000, 24, 0, 0), mk(1, 1, 2000, 0, 0, 0));
    add_pair(mk(1, 1, 2000, 0, 60, 0), mk(1, 1, 2000, 0, 0, 0));
    add_pair(mk(1, 1, 2000, 0, 0, 60), mk(1, 1, 2000, 0, 0, 0));
    add_pair(mk(1, 1, 2000, 0, 0, 0), mk(1, 1, 2000, 31, 0, 0));
    add_pair(mk(1, 1, 2000, 0, 0, 0), mk(1, 1, 2000, 0, 63, 0));
    add_pair(mk(1, 1, 2000, 0, 0, 0), mk(1, 1, 2000, 0, 0, 63));
    // borrows across day, year and century boundaries
    add_pair(mk(1, 3, 2000, 0, 0, 0), mk(28, 2, 2000, 23, 59, 59));
    add_pair(mk(31, 12, 1999, 23, 59, 59), mk(1, 1, 2000, 0, 0, 0));
    add_pair(mk(1, 3, 2100, 0, 0, 1), mk(28, 2, 2100, 0, 0, 2));

    for (int i = 0; i < N_RANDOM; i++) begin
      pair_t p;
      p = random_pair();
      p.drain = (i == 0) || (i == N_RANDOM / 2);
      stim_q.push_back(p);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() > 0 || in_valid_i || diff_q.size() > 0) @(posedge clk_i);
    // let any stray result show up
    for (settle = 0; settle < 20; settle++) @(posedge clk_i);
    if (diff_q.size() != 0) begin
      $display("%0d results never arrived", diff_q.size());
      fail_count += diff_q.size();
    end

    $display("Sent %0d timestamp pairs: %0d both valid, %0d rejected",
             sent_count, n_valid, n_bad);
    $display("Order seen: %0d later, %0d earlier, %0d equal; %0d failures",
             n_later, n_earlier, n_equal, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d pairs queued, %0d results pending",
             stim_q.size(), diff_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
